[hdl/congestion_window_controller_assert.svh]
// Assertion macros for the congestion window controller checker
`ifndef CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH
`define CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH

// overlapping implication, sampled on clk, off during reset
`define CWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwc assertion failed");

`endif

[hdl/cwc_pkg.sv]
// Types and constants for the congestion window controller
`default_nettype none

package cwc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int TIME_W  = 32;   // width of send_time / ack_time fields
  localparam int REG_W   = 16;   // configuration register width
  localparam int WHOLE_W = 16;   // integer bits of the window
  localparam int CNT_W   = 16;   // timeout counter width
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] RST_TIMEOUT_LIMIT = 16'd90;
  localparam logic [REG_W-1:0] RST_INIT_WINDOW   = 16'd13;
  localparam logic [REG_W-1:0] RST_INIT_THRESH   = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_START,
    ST_WAIT,
    ST_ADD,
    ST_OUT
  } cwc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } recip_sts_t;

endpackage

`default_nettype wire

[hdl/cwc_recip.sv]
// Shift-subtract reciprocal unit: 2^(2*FRAC_BITS) / divisor, one quotient bit per cycle
`default_nettype none

module cwc_recip import cwc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [WHOLE_W+FRAC_BITS-1:0]  divisor,
  output logic      [2*FRAC_BITS:0]          quotient,
  output recip_sts_t                         sts
);

  localparam int WIN_W = WHOLE_W + FRAC_BITS;
  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int CW    = $clog2(QW);

  logic [WIN_W-1:0] div_r;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    q_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIN_W:0]   trial;
  logic             ge;

  // dividend is a single one in its top bit, so only the first step shifts in a 1
  always_comb begin
    trial   = {rem_r, (cnt_r == CW'(QW - 1))};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? WIN_W'(trial - {1'b0, div_r}) : trial[WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

[hdl/congestion_window_controller.sv]
// Sequence: an accepted ack passes through the evaluate, start and output states; when it
// adds 1/window (window Q16.16 by default), the shift-subtract reciprocal unit runs between.
// Throughput: one ack at a time; the next is taken the cycle after the result is registered,
// and a registered result may wait for out_tready while the next ack is taken.
// Reset (rst_n low, synchronous): registers to 90/13/1000, window and threshold loaded,
// saved window, timeout count and phase cleared, no result pending.
`default_nettype none

module congestion_window_controller import cwc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // ack in
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,   // [31:0] send_time, [63:32] ack_time
  // result out
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [15:0]          out_tdata,  // [15:0] window_whole
  output logic      [1:0]           out_tuser,  // [0] in_avoidance, [1] timed_out
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  localparam int WIN_W = WHOLE_W + FRAC_BITS;
  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int SUM_W = ((WIN_W > QW) ? WIN_W : QW) + 1;
  localparam int CMP_W = WIN_W + 2;
  localparam int XW    = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  function automatic logic [WIN_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    return (s > SUM_W'(WIN_MAX)) ? WIN_MAX : s[WIN_W-1:0];
  endfunction

  cwc_state_t state_r, state_nxt;

  logic [WIN_W-1:0] window_r, window_nxt;
  logic [WIN_W-1:0] thresh_r, thresh_nxt;
  logic [WIN_W-1:0] saved_r, saved_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             phase_r, phase_nxt;
  logic             tout_r, tout_nxt;
  logic             recip_r, recip_nxt;
  logic [REG_W-1:0] limit_r, limit_nxt;
  logic [TIME_W-1:0] send_r, ack_r;

  logic             out_valid_r, out_valid_nxt;
  logic [WHOLE_W-1:0] out_win_r;
  logic             out_avoid_r, out_tout_r;
  logic             out_load;

  logic             recip_start;
  logic [QW-1:0]    recip_q;
  recip_sts_t       recip_sts;

  logic [TIME_BITS-1:0] rtt;
  logic             tout;
  logic [17:0]      cnt_x3;
  logic             rep_clear;
  logic [CNT_W-1:0] count_inc;
  logic [WIN_W-1:0] half_win;
  logic [WIN_W-1:0] recip_val;

  cwc_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (recip_start),
    .divisor  (window_r),
    .quotient (recip_q),
    .sts      (recip_sts)
  );

  always_comb begin
    rtt       = TIME_BITS'(XW'(ack_r) - XW'(send_r));
    tout      = rtt >= TIME_BITS'(limit_r);
    cnt_x3    = {2'b00, count_r} + {1'b0, count_r, 1'b0};
    // saved/1.5 <= count, done exactly as 2*saved <= 3*count
    rep_clear = (count_r != '0) &&
                (CMP_W'({saved_r, 1'b0}) <= (CMP_W'(cnt_x3) << FRAC_BITS));
    count_inc = (count_r != '1) ? count_r + 1'b1 : count_r;
    half_win  = window_r >> 1;
    // zero window only comes from a zero initial window; saturate
    recip_val = (window_r == '0) ? WIN_MAX : WIN_W'(recip_q);
  end

  always_comb begin
    state_nxt   = state_r;
    window_nxt  = window_r;
    thresh_nxt  = thresh_r;
    saved_nxt   = saved_r;
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    tout_nxt    = tout_r;
    recip_nxt   = recip_r;
    limit_nxt   = limit_r;
    in_tready   = 1'b0;
    recip_start = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        tout_nxt  = tout;
        recip_nxt = phase_r;
        priority if (tout && (saved_r == '0)) begin
          phase_nxt  = 1'b0;
          saved_nxt  = window_r;
          count_nxt  = count_inc;
          thresh_nxt = half_win;
          window_nxt = sat_add(SUM_W'(half_win), SUM_W'(3) << FRAC_BITS);
        end else if (tout && rep_clear) begin
          count_nxt = '0;
          saved_nxt = '0;
        end else if (tout) begin
          count_nxt = count_inc;
        end else if (!phase_r) begin
          if (window_r > thresh_r) begin
            phase_nxt = 1'b1;
            recip_nxt = 1'b1;
          end else begin
            window_nxt = sat_add(SUM_W'(window_r), SUM_W'(2) << FRAC_BITS);
          end
        end else begin
          // avoidance without timeout: only the reciprocal add below
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        if (recip_r) begin
          recip_start = 1'b1;
          state_nxt   = ST_WAIT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_WAIT: begin
        if (recip_sts.done) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        window_nxt = sat_add(SUM_W'(window_r), SUM_W'(recip_val));
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register writes are to come only while idle; the user must keep to this, the block does not enforce it
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMEOUT_LIMIT: limit_nxt = cfg_data;
        REG_INIT_WINDOW:   window_nxt = WIN_W'(cfg_data) << FRAC_BITS;
        REG_INIT_THRESH:   thresh_nxt = WIN_W'(cfg_data) << FRAC_BITS;
        default: ;
      endcase
    end

    out_valid_nxt = out_load | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WIN_W'(RST_INIT_WINDOW) << FRAC_BITS;
      thresh_r    <= WIN_W'(RST_INIT_THRESH) << FRAC_BITS;
      saved_r     <= '0;
      count_r     <= '0;
      phase_r     <= 1'b0;
      tout_r      <= 1'b0;
      recip_r     <= 1'b0;
      limit_r     <= RST_TIMEOUT_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      saved_r     <= saved_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      tout_r      <= tout_nxt;
      recip_r     <= recip_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      send_r <= in_tdata[TIME_W-1:0];
      ack_r  <= in_tdata[2*TIME_W-1:TIME_W];
    end
    if (out_load) begin
      out_win_r   <= window_r[FRAC_BITS +: WHOLE_W];
      out_avoid_r <= phase_r;
      out_tout_r  <= tout_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_win_r;
  assign out_tuser  = {out_tout_r, out_avoid_r};

endmodule

`default_nettype wire

[hdl/cwc_checker.sv]
// Port-level checks for the congestion window controller, bound to the top level
`default_nettype none

`include "congestion_window_controller_assert.svh"

module cwc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result holds
  `CWC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one ack at a time: busy right after taking one
  `CWC_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a result never shows up sooner than the evaluate and register steps allow
  `CWC_ASSERT_IMP(a_min_latency, in_tvalid && in_tready, ##2 (!in_tready && !$rose(out_tvalid)))

  // results are registered only from the busy side of the sequencer
  `CWC_ASSERT_IMP(a_rise_when_busy, $rose(out_tvalid), $past(!in_tready))

endmodule

bind congestion_window_controller cwc_checker u_cwc_checker (.*);

`default_nettype wire

[bench/cwnd_checker.sv]
// Scoreboard for the congestion window controller: predicts each result and compares it
module cwnd_checker import cwc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] send_time, [63:32] ack_time
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,  // [15:0] window_whole
  input  logic [1:0]           out_tuser,  // [0] in_avoidance, [1] timed_out
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 run_done,
  output int                   fail_count
);

  localparam int WIN_W = WHOLE_W + FRAC_BITS_DEF;
  localparam logic [63:0] WIN_MAX = (64'd1 << WIN_W) - 64'd1;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS_DEF;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic               avoid;
    logic               tout;
  } cwnd_result_t;

  logic [REG_W-1:0] limit_ms;
  logic [WIN_W-1:0] cwnd;
  logic [WIN_W-1:0] ssthresh;
  logic [WIN_W-1:0] saved_cwnd;
  logic [CNT_W-1:0] tout_count;
  logic             avoiding;
  logic             leftover_checked;

  cwnd_result_t pending_windows[$];
  cwnd_result_t want;

  function automatic logic [WIN_W-1:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (s > WIN_MAX) return WIN_MAX[WIN_W-1:0];
    return s[WIN_W-1:0];
  endfunction

  // truncated 1/window; a zero window yields the largest value
  function automatic logic [63:0] recip(logic [WIN_W-1:0] w);
    if (w == '0) return WIN_MAX;
    return (64'd1 << (2 * FRAC_BITS_DEF)) / {32'd0, w};
  endfunction

  function automatic cwnd_result_t next_window(logic [TIME_W-1:0] send_ms,
                                               logic [TIME_W-1:0] ack_ms);
    logic [TIME_W-1:0] rtt;
    logic              tout;
    logic              was_avoid;
    cwnd_result_t      r;
    rtt = ack_ms - send_ms;
    tout = rtt >= {16'd0, limit_ms};
    was_avoid = avoiding;
    if (tout && saved_cwnd == '0) begin
      avoiding = 1'b0;
      saved_cwnd = cwnd;
      if (tout_count != '1) tout_count = tout_count + 1'b1;
      ssthresh = cwnd >> 1;
      cwnd = sat_add({32'd0, ssthresh}, 3 * ONE_Q);
    end else if (tout && tout_count != '0 &&
                 ({32'd0, saved_cwnd} << 1) <= (({48'd0, tout_count} * 64'd3) << FRAC_BITS_DEF)) begin
      tout_count = '0;
      saved_cwnd = '0;
    end else if (tout) begin
      if (tout_count != '1) tout_count = tout_count + 1'b1;
    end else if (!was_avoid) begin
      if (cwnd > ssthresh) begin
        cwnd = sat_add({32'd0, cwnd}, recip(cwnd));
        avoiding = 1'b1;
      end else begin
        cwnd = sat_add({32'd0, cwnd}, 2 * ONE_Q);
      end
    end
    // avoidance keeps adding 1/window, timeout or not
    if (was_avoid) cwnd = sat_add({32'd0, cwnd}, recip(cwnd));
    r.whole = cwnd[WIN_W-1 -: WHOLE_W];
    r.avoid = avoiding;
    r.tout = tout;
    return r;
  endfunction

  task automatic check_field(string label, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_ms = RST_TIMEOUT_LIMIT;
      cwnd = WIN_W'(RST_INIT_WINDOW) << FRAC_BITS_DEF;
      ssthresh = WIN_W'(RST_INIT_THRESH) << FRAC_BITS_DEF;
      saved_cwnd = '0;
      tout_count = '0;
      avoiding = 1'b0;
      leftover_checked = 1'b0;
      fail_count = 0;
      pending_windows.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_windows.size() == 0) begin
          $display("%0t: unexpected result, window_whole %0d tuser %b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = pending_windows.pop_front();
          check_field("window_whole", want.whole, out_tdata);
          check_field("in_avoidance", want.avoid, out_tuser[0]);
          check_field("timed_out", want.tout, out_tuser[1]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMEOUT_LIMIT: limit_ms = cfg_data;
          REG_INIT_WINDOW:   cwnd = WIN_W'(cfg_data) << FRAC_BITS_DEF;
          REG_INIT_THRESH:   ssthresh = WIN_W'(cfg_data) << FRAC_BITS_DEF;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_windows.push_back(next_window(in_tdata[31:0], in_tdata[63:32]));
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_windows.size() != 0) begin
          $display("%0t: %0d results expected but never seen", $time,
                   pending_windows.size());
          fail_count += pending_windows.size();
        end
      end
    end
  end

endmodule

[bench/tb_congestion_window_controller.sv]
// Top of the congestion window controller bench: clock, reset, acks, register writes, verdict
module tb_congestion_window_controller;
  import cwc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
  localparam int IDLE_LIMIT = 4000;
  localparam int ACK_TARGET = 1450;
  localparam int DRAIN_CYCLES = 45;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [63:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 run_done;
  int                   fail_count;

  int acks_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [REG_W-1:0] cur_limit = RST_TIMEOUT_LIMIT;

  always #5 clk = ~clk;

  congestion_window_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cwnd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .run_done   (run_done),
    .fail_count (fail_count)
  );

  // handshake counts and the watchdog
  always @(posedge clk) begin
    if (in_tvalid && in_tready) acks_sent <= acks_sent + 1;
    if (out_tvalid && out_tready) results_seen <= results_seen + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[congestion_window_controller] ERROR");
      $finish;
    end
  end

  // result side: random out_tready stall patterns, each mode drawn anew when its run ends
  initial begin
    int mode;
    int mode_left;
    int tick;
    out_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 250);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 9) < 7);
        2: out_tready = ($urandom_range(0, 9) < 2);
        default: out_tready = (tick % 6 == 0);
      endcase
    end
  end

  task automatic send_ack(logic [31:0] send_ms, logic [31:0] ack_ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        in_tdata = {$urandom, $urandom};
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {ack_ms, send_ms};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender until every result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_seen != acks_sent) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_TIMEOUT_LIMIT) cur_limit = value;
  endtask

  function automatic logic [REG_W-1:0] pick_reg(int small_hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      3, 4, 5: return REG_W'($urandom_range(1, small_hi));
      default: return REG_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // acks with round trip times drawn around the current timeout limit
  task automatic send_batch(int count, int tout_pct);
    int pick;
    logic [31:0] send_ms;
    logic [31:0] rtt;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      send_ms = $urandom;
      if (pick < 8) begin
        rtt = $urandom;
      end else if (pick < 8 + tout_pct) begin
        case ($urandom_range(0, 3))
          0:       rtt = 32'(cur_limit);
          1:       rtt = 32'(cur_limit) + $urandom_range(0, 500);
          2:       rtt = $urandom | 32'h8000_0000;
          default: rtt = '1;
        endcase
      end else if (cur_limit == '0) begin
        rtt = $urandom_range(0, 100);
      end else begin
        case ($urandom_range(0, 2))
          0:       rtt = 32'(cur_limit) - 32'd1;
          1:       rtt = '0;
          default: rtt = $urandom_range(0, 32'(cur_limit) - 32'd1);
        endcase
      end
      send_ack(send_ms, send_ms + rtt);
    end
  endtask

  initial begin
    int mask;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TIMEOUT_LIMIT;
    cfg_data = '0;
    run_done = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: time extremes, wrapped rtt, limit edge, first and repeated timeout
    send_ack(32'h0000_0000, 32'h0000_0000);
    send_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ack(32'd100, 32'd189);
    send_ack(32'hFFFF_FFF0, 32'h0000_0010);
    send_ack(32'd5, 32'd95);
    send_ack(32'h0000_0001, 32'h0000_0000);
    send_ack(32'h0000_0000, 32'hFFFF_FFFF);
    send_ack(32'hAAAA_AAAA, 32'hAAAA_AAAB);
    send_ack(32'h5555_5555, 32'h5555_5557);
    for (int i = 0; i < 6; i++) send_ack($urandom, $urandom);

    // enter avoidance, then drop the window to zero: reciprocal saturates
    wait_idle();
    write_reg(REG_SPARE, 16'hA5A5);
    write_reg(REG_TIMEOUT_LIMIT, '1);
    write_reg(REG_INIT_WINDOW, 16'd1);
    write_reg(REG_INIT_THRESH, '0);
    send_ack(32'd7, 32'd8);
    send_ack(32'd7, 32'd9);
    send_ack(32'd7, 32'd10);
    wait_idle();
    write_reg(REG_INIT_WINDOW, '0);
    send_ack(32'd3, 32'd4);
    send_ack(32'd3, 32'd5);

    // zero limit: every ack times out, starting from a zero window
    wait_idle();
    write_reg(REG_TIMEOUT_LIMIT, '0);
    write_reg(REG_INIT_WINDOW, '0);
    write_reg(REG_INIT_THRESH, '0);
    for (int i = 0; i < 4; i++) send_ack($urandom, $urandom);

    // largest window and threshold: slow start saturates
    wait_idle();
    write_reg(REG_TIMEOUT_LIMIT, '1);
    write_reg(REG_INIT_WINDOW, '1);
    write_reg(REG_INIT_THRESH, '1);
    send_ack(32'd0, 32'd65534);
    send_ack(32'd10, 32'd20);
    send_ack(32'd0, 32'd65535);

    // random phases, each with its own settings and timeout rate
    while (acks_sent < ACK_TARGET) begin
      wait_idle();
      mask = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, REG_W'($urandom));
      if (mask[0]) write_reg(REG_TIMEOUT_LIMIT, pick_reg(300));
      if (mask[1]) write_reg(REG_INIT_WINDOW, pick_reg(20));
      if (mask[2]) write_reg(REG_INIT_THRESH, pick_reg(40));
      send_batch($urandom_range(60, 160), $urandom_range(5, 60));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_done = 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0)
      $display("[congestion_window_controller] OK");
    else
      $display("[congestion_window_controller] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/cwc_pkg.sv
hdl/cwc_recip.sv
hdl/congestion_window_controller.sv
hdl/cwc_checker.sv
bench/cwnd_checker.sv
bench/tb_congestion_window_controller.sv
